// File: rtl/core/text_line_editor_stack_defines.svh
// Assertion macros for the checker file of the line editor.
`ifndef TEXT_LINE_EDITOR_STACK_DEFINES_SVH
`define TEXT_LINE_EDITOR_STACK_DEFINES_SVH

// Checked only while reset is released.
`define TLES_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define TLES_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: rtl/core/tles_pkg.sv
`default_nettype none

package tles_pkg;

    // Register indexes on the configuration channel.
    localparam logic [2:0] CFG_ERASE      = 3'd0;
    localparam logic [2:0] CFG_KILL       = 3'd1;
    localparam logic [2:0] CFG_PRINT      = 3'd2;
    localparam logic [2:0] CFG_END        = 3'd3;
    localparam logic [2:0] CFG_WORD_ERASE = 3'd4;

    // Reset values of the control codes.
    localparam logic [7:0] RST_ERASE      = 8'd35;
    localparam logic [7:0] RST_KILL       = 8'd92;
    localparam logic [7:0] RST_PRINT      = 8'd42;
    localparam logic [7:0] RST_END        = 8'd126;
    localparam logic [7:0] RST_WORD_ERASE = 8'd36;

    localparam logic [7:0] CHAR_NL = 8'd10;
    localparam logic [7:0] CHAR_SP = 8'd32;

    typedef enum logic [2:0] {
        OP_STORE,
        OP_ERASE,
        OP_KILL,
        OP_PRINT,
        OP_END,
        OP_WERASE,
        OP_NOP
    } t_op;

    // One classified byte. The alternate op is what an erase turns into
    // when it meets an empty buffer.
    typedef struct packed {
        t_op        op;
        t_op        alt;
        logic [7:0] ch;
    } t_cmd;

endpackage

`default_nettype wire

// File: rtl/core/text_line_editor_stack.sv
// Stack-based line editor. Text bytes enter on the s_axis channel, one byte per
// transaction. Control codes (erase, kill, print, end mark, word erase) are held
// in five 8-bit registers written over the configuration channel at indexes 0..4;
// writes to other indexes are accepted and ignored. Configuration must only be
// written while the block is idle.
// Emitted lines leave on the m_axis channel oldest byte first; the newline that
// closes a line carries tlast.
// A front stage classifies each byte against the control codes and pushes it into
// a two-entry command queue; the back stage owns the line buffer and executes.
// Ordinary bytes and single erases sustain one transaction per cycle while the
// back stage is idle. A flush reads each buffered byte through the registered
// read port of the line buffer, emits it, and then emits the newline; a word
// erase pops bytes until it has popped a space or the buffer is empty. The back
// stage takes no new command until either is done. When the receiver stalls,
// the output register holds its beat, the back stage waits, and the queue fills
// until s_axis_tready drops.
// Reset (synchronous, active low) empties the buffer and the queue and restores
// the default codes; the buffer contents themselves are not cleared.
`default_nettype none

module text_line_editor_stack
    import tles_pkg::*;
#(
    parameter int LINE_DEPTH = 32
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [2:0] i_cfg_index,
    input  wire logic [7:0] i_cfg_data,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] in_char
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // [7:0] out_char
    output logic            m_axis_tlast    // last
);

    logic w_push;
    logic w_full;
    logic w_q_valid;
    logic w_q_pop;
    t_cmd w_push_cmd;
    t_cmd w_q_cmd;

    // Front: configuration registers and byte classification.
    tles_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .i_full        (w_full),
        .o_push        (w_push),
        .o_cmd         (w_push_cmd)
    );

    // The queue lets the front keep taking bytes while the back is flushing.
    tles_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd),
        .i_pop   (w_q_pop)
    );

    // Back: line buffer, fill level and the output register.
    tles_back #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_q_valid),
        .i_cmd       (w_q_cmd),
        .o_cmd_ready (w_q_pop),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_char  (m_axis_tdata),
        .o_out_last  (m_axis_tlast)
    );

endmodule

`default_nettype wire

// File: rtl/core/tles_front.sv
`default_nettype none

module tles_front
    import tles_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [2:0] i_cfg_index,
    input  wire logic [7:0] i_cfg_data,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] in_char
    input  wire logic       i_full,
    output logic            o_push,
    output t_cmd            o_cmd
);

    logic [7:0] r_erase;
    logic [7:0] r_kill;
    logic [7:0] r_print;
    logic [7:0] r_end;
    logic [7:0] r_werase;
    logic [7:0] w_ch;
    t_op        w_alt;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_erase  <= RST_ERASE;
            r_kill   <= RST_KILL;
            r_print  <= RST_PRINT;
            r_end    <= RST_END;
            r_werase <= RST_WORD_ERASE;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ERASE:      r_erase  <= i_cfg_data;
                CFG_KILL:       r_kill   <= i_cfg_data;
                CFG_PRINT:      r_print  <= i_cfg_data;
                CFG_END:        r_end    <= i_cfg_data;
                CFG_WORD_ERASE: r_werase <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // A newline is handled as a space from here on.
    assign w_ch = (s_axis_tdata == CHAR_NL) ? CHAR_SP : s_axis_tdata;

    always_comb begin
        priority if (w_ch == r_kill)  w_alt = OP_KILL;
        else if (w_ch == r_print)     w_alt = OP_PRINT;
        else                          w_alt = OP_STORE;
    end

    always_comb begin
        o_cmd.ch  = w_ch;
        o_cmd.alt = w_alt;
        priority if (w_ch == r_end) begin
            o_cmd.op = OP_END;
        end else if (w_ch == r_werase) begin
            // A word-erase code of space stops before popping anything.
            o_cmd.op = (w_ch == CHAR_SP) ? OP_NOP : OP_WERASE;
        end else if (w_ch == r_erase) begin
            o_cmd.op = OP_ERASE;
        end else begin
            o_cmd.op = w_alt;
        end
    end

    assign s_axis_tready = !i_full;
    assign o_push        = s_axis_tvalid && !i_full;

endmodule

`default_nettype wire

// File: rtl/core/tles_fifo.sv
`default_nettype none

module tles_fifo
    import tles_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    output logic      o_full,
    output logic      o_valid,
    output t_cmd      o_cmd,
    input  wire logic i_pop
);

    t_cmd       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_wr;
    logic       w_rd;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_mem[r_rp];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) r_wp <= !r_wp;
            if (w_rd) r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, w_wr} - {1'b0, w_rd};
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/tles_back.sv
`default_nettype none

module tles_back
    import tles_pkg::*;
#(
    parameter int LINE_DEPTH = 32
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cmd_valid,
    input  wire t_cmd       i_cmd,
    output logic            o_cmd_ready,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [7:0]      o_out_char,
    output logic            o_out_last
);

    localparam int AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int CW = $clog2(LINE_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FL_READ,
        S_FL_EMIT,
        S_WE_READ,
        S_WE_CHK
    } t_state;

    t_state        r_state;
    logic [CW-1:0] r_fill;
    logic [CW-1:0] r_idx;
    logic          r_pend;
    logic [7:0]    r_ch;
    logic [7:0]    r_rd_data;
    logic          r_out_valid;
    logic [7:0]    r_out_char;
    logic          r_out_last;
    logic [7:0]    r_line [LINE_DEPTH];

    logic [CW-1:0] w_top;
    logic          w_full;
    logic          w_out_free;
    logic          w_take;
    t_op           w_op;
    logic          w_wr_en;
    logic [AW-1:0] w_wr_addr;
    logic [7:0]    w_wr_data;
    logic          w_rd_en;
    logic [AW-1:0] w_rd_addr;

    assign w_top       = r_fill - CW'(1);
    assign w_full      = (r_fill == CW'(LINE_DEPTH));
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_cmd_ready = (r_state == S_IDLE);
    assign w_take      = o_cmd_ready && i_cmd_valid;
    assign w_op        = (i_cmd.op == OP_ERASE && r_fill == '0) ? i_cmd.alt : i_cmd.op;

    assign w_wr_en = (w_take && w_op == OP_STORE && !w_full)
                  || (r_state == S_FL_READ && r_idx == r_fill && w_out_free && r_pend);
    assign w_wr_addr = (r_state == S_IDLE) ? r_fill[AW-1:0] : '0;
    assign w_wr_data = (r_state == S_IDLE) ? i_cmd.ch : r_ch;

    assign w_rd_en = (r_state == S_FL_READ && r_idx != r_fill)
                  || (r_state == S_WE_READ && r_fill != '0);
    assign w_rd_addr = (r_state == S_FL_READ) ? r_idx[AW-1:0] : w_top[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_line[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rd_data <= r_line[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_out_ready) r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        unique case (w_op)
                            OP_END: begin
                                if (r_fill != '0) begin
                                    r_idx   <= '0;
                                    r_pend  <= 1'b0;
                                    r_state <= S_FL_READ;
                                end
                            end
                            OP_WERASE: r_state <= S_WE_READ;
                            OP_ERASE:  r_fill  <= w_top;
                            OP_KILL:   r_fill  <= '0;
                            OP_PRINT: begin
                                r_idx   <= '0;
                                r_pend  <= 1'b0;
                                r_state <= S_FL_READ;
                            end
                            OP_STORE: begin
                                if (w_full) begin
                                    // Flush first; the byte is stored with the newline.
                                    r_idx   <= '0;
                                    r_pend  <= 1'b1;
                                    r_ch    <= i_cmd.ch;
                                    r_state <= S_FL_READ;
                                end else begin
                                    r_fill <= r_fill + CW'(1);
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_FL_READ: begin
                    if (r_idx != r_fill) begin
                        r_state <= S_FL_EMIT;
                    end else if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_char  <= CHAR_NL;
                        r_out_last  <= 1'b1;
                        r_fill      <= r_pend ? CW'(1) : '0;
                        r_state     <= S_IDLE;
                    end
                end
                S_FL_EMIT: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_char  <= r_rd_data;
                        r_out_last  <= 1'b0;
                        r_idx       <= r_idx + CW'(1);
                        r_state     <= S_FL_READ;
                    end
                end
                S_WE_READ: begin
                    if (r_fill == '0) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_fill  <= w_top;
                        r_state <= S_WE_CHK;
                    end
                end
                S_WE_CHK: begin
                    r_state <= (r_rd_data == CHAR_SP) ? S_IDLE : S_WE_READ;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_out_last  = r_out_last;

endmodule

`default_nettype wire

// File: rtl/core/tles_checker.sv
`default_nettype none
`include "text_line_editor_stack_defines.svh"

module tles_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       m_axis_tvalid,
    input wire logic       m_axis_tready,
    input wire logic [7:0] m_axis_tdata,
    input wire logic       m_axis_tlast
);

    `TLES_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "output dropped while stalled")
    `TLES_ASSERT(a_out_stable, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast), "output changed while stalled")
    `TLES_ASSERT(a_last_is_nl, m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata == 8'd10)), "tlast must mark exactly the newline")
    `TLES_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> !m_axis_tvalid, "output valid after reset")

endmodule

bind text_line_editor_stack tles_checker u_tles_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
